// ----- rtl/voq_round_robin_matching_unit_macros.svh -----
// ----------------------------------------------------------------------------
// voq_round_robin_matching_unit_macros.svh
// assertion helpers for the voq round-robin matcher, clocked on clk
// ----------------------------------------------------------------------------
`ifndef VOQ_ROUND_ROBIN_MATCHING_UNIT_MACROS_SVH
`define VOQ_ROUND_ROBIN_MATCHING_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VRRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define VRRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/voq_rr_pkg.sv -----
// ----------------------------------------------------------------------------
// voq_rr_pkg
// shared widths, constants and structs of the voq round-robin matcher
// ----------------------------------------------------------------------------
package voq_rr_pkg;

  // ports carried by the packed stream fields
  localparam int FIELD_PORTS = 8;
  localparam int DEST_BITS   = 3;

  // configuration register
  localparam int         CFG_W     = 4;
  localparam logic [3:0] CFG_RESET = 4'd4;

  // stream payload widths
  localparam int IN_W  = 32;
  localparam int OUT_W = 40;

  // per-input lane report for one slot
  typedef struct packed {
    logic                 dropped;
    logic                 matched;
    logic [DEST_BITS-1:0] port;
  } lane_status_t;

  // one result, match_valid in the lowest bits
  typedef struct packed {
    logic [FIELD_PORTS-1:0]           arrival_dropped;
    logic [FIELD_PORTS*DEST_BITS-1:0] match_output;
    logic [FIELD_PORTS-1:0]           match_valid;
  } result_t;

endpackage

// ----- rtl/voq_rr_arbiter.sv -----
// ----------------------------------------------------------------------------
// voq_rr_arbiter
// rotating priority encoder: first request at or after the pointer
// ----------------------------------------------------------------------------
module voq_rr_arbiter #(
  parameter int N  = 8,
  parameter int PW = 3
) (
  input  logic [N-1:0]  req,
  input  logic [PW-1:0] ptr,
  output logic [N-1:0]  gnt,
  output logic [PW-1:0] idx,
  output logic          any
);

  logic [N-1:0] at_or_above;
  logic [N-1:0] masked;
  logic [N-1:0] sel;

  // split requests into the part of the ring at or above the pointer and the wrap-around
  always_comb begin
    for (int k = 0; k < N; k++) begin
      at_or_above[k] = (PW'(k) >= ptr);
    end
    masked = req & at_or_above;
    sel    = (|masked) ? masked : req;
  end

  // lowest set bit of the selected part wins
  always_comb begin
    idx = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (sel[k]) begin
        idx = PW'(k);
      end
    end
    any = |req;
    gnt = any ? (N'(1) << idx) : '0;
  end

endmodule

// ----- rtl/voq_rr_output_lane.sv -----
// ----------------------------------------------------------------------------
// voq_rr_output_lane
// grant stage of one output port with its round-robin grant pointer
// ----------------------------------------------------------------------------
module voq_rr_output_lane #(
  parameter int PORTS = 8,
  parameter int PW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [PORTS-1:0] request_col,
  input  logic [PORTS-1:0] accept_col,
  output logic [PORTS-1:0] grant
);

  logic [PW-1:0] ptr_r;
  logic [PW-1:0] ptr_nxt;
  logic [PW-1:0] g_idx;
  logic          g_any;

  // pick one requesting input
  voq_rr_arbiter #(
    .N  (PORTS),
    .PW (PW)
  ) u_grant (
    .req (request_col),
    .ptr (ptr_r),
    .gnt (grant),
    .idx (g_idx),
    .any (g_any)
  );

  // pointer moves one past the input only when the grant was accepted
  always_comb begin
    ptr_nxt = ptr_r;
    if (g_any && (|accept_col)) begin
      ptr_nxt = (g_idx == PW'(PORTS - 1)) ? '0 : g_idx + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (step) begin
      ptr_r <= ptr_nxt;
    end
  end

endmodule

// ----- rtl/voq_rr_input_lane.sv -----
// ----------------------------------------------------------------------------
// voq_rr_input_lane
// one input port: voq counters, arrival admission and accept stage
// ----------------------------------------------------------------------------
module voq_rr_input_lane #(
  parameter int PORTS = 8,
  parameter int OW    = 4,
  parameter int PW    = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     arr_valid,
  input  logic [2:0]               arr_dest,
  input  logic [OW-1:0]            limit,
  input  logic [PORTS-1:0]         grant_in,
  output logic [PORTS-1:0]         request,
  output logic [PORTS-1:0]         accept,
  output voq_rr_pkg::lane_status_t status
);

  import voq_rr_pkg::*;

  localparam int DW = 5;

  logic [OW-1:0]    voq_r   [PORTS];
  logic [OW-1:0]    voq_nxt [PORTS];
  logic [OW-1:0]    occ_r;
  logic [OW-1:0]    occ_nxt;
  logic [PW-1:0]    ptr_r;
  logic [PW-1:0]    ptr_nxt;
  logic [DW-1:0]    dest_ext;
  logic             admit;
  logic [PORTS-1:0] hit;
  logic [PW-1:0]    acc_idx;
  logic             acc_any;

  // admission: legal destination and room left under the limit
  always_comb begin
    dest_ext = DW'(arr_dest);
    admit    = arr_valid && (dest_ext < DW'(PORTS)) && (occ_r < limit);
    for (int j = 0; j < PORTS; j++) begin
      hit[j]     = admit && (dest_ext == DW'(j));
      request[j] = (voq_r[j] != '0) || hit[j];
    end
  end

  // accept the first granting output from the accept pointer
  voq_rr_arbiter #(
    .N  (PORTS),
    .PW (PW)
  ) u_accept (
    .req (grant_in),
    .ptr (ptr_r),
    .gnt (accept),
    .idx (acc_idx),
    .any (acc_any)
  );

  // counter and pointer updates for this slot
  always_comb begin
    for (int j = 0; j < PORTS; j++) begin
      voq_nxt[j] = voq_r[j] + OW'(hit[j]) - OW'(accept[j]);
    end
    occ_nxt = occ_r + OW'(admit) - OW'(acc_any);
    ptr_nxt = ptr_r;
    if (acc_any) begin
      ptr_nxt = (acc_idx == PW'(PORTS - 1)) ? '0 : acc_idx + PW'(1);
    end
  end

  // slot report
  always_comb begin
    status.dropped = arr_valid && !admit;
    status.matched = acc_any;
    status.port    = acc_any ? DEST_BITS'(acc_idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PORTS; j++) begin
        voq_r[j] <= '0;
      end
      occ_r <= '0;
      ptr_r <= '0;
    end else if (step) begin
      for (int j = 0; j < PORTS; j++) begin
        voq_r[j] <= voq_nxt[j];
      end
      occ_r <= occ_nxt;
      ptr_r <= ptr_nxt;
    end
  end

endmodule

// ----- rtl/voq_rr_out_buf.sv -----
// ----------------------------------------------------------------------------
// voq_rr_out_buf
// output register with a skid stage on the result stream
// ----------------------------------------------------------------------------
module voq_rr_out_buf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  voq_rr_pkg::result_t         din,
  output logic                        ready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [voq_rr_pkg::OUT_W-1:0] out_tdata
);

  import voq_rr_pkg::*;

  result_t out_r;
  result_t out_nxt;
  result_t skid_r;
  result_t skid_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  logic    pop;

  assign ready      = !skid_valid_r;
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // refill the output register from skid first, then from the new result
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = din;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = din;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- rtl/voq_round_robin_matching_unit.sv -----
// ----------------------------------------------------------------------------
// voq_round_robin_matching_unit
// single-iteration round-robin matcher for an input-queued crossbar
// ----------------------------------------------------------------------------
// Each transfer on the in_ stream is one cell slot: an arrival bit and a
// 3-bit destination per input port. Arrivals are admitted into the per-input
// virtual output queue counters while the input holds fewer cells than the
// configured limit, else reported as dropped. One grant/accept pass then
// matches inputs to outputs and dequeues the matched cells.
// Each slot yields exactly one transfer on the out_ stream, from the output
// register. One slot is taken every cycle while in_tready is high; the whole
// slot (admission, grant arbiters, accept arbiters, counter update) is
// resolved combinationally in the cycle of the input transfer.
// A skid register behind the output register lets the block take one more
// slot after the receiver stalls; in_tready then stays low until the
// receiver takes the next out_ transfer.
// Reset clears all queue counters and pointers, empties the output stages
// and sets the buffer limit to 4. cfg_wr_en writes the limit at once.
// ----------------------------------------------------------------------------
`include "voq_round_robin_matching_unit_macros.svh"

module voq_round_robin_matching_unit #(
  parameter int PORTS      = 8,
  parameter int BUFFER_MAX = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // arrival_valid [7:0], arrival_dest [31:8]
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [voq_rr_pkg::IN_W-1:0]  in_tdata,
  // match_valid [7:0], match_output [31:8], arrival_dropped [39:32]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [voq_rr_pkg::OUT_W-1:0] out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [voq_rr_pkg::CFG_W-1:0] cfg_wr_data
);

  import voq_rr_pkg::*;

  localparam int PW = $clog2(PORTS);
  localparam int OW = $clog2(BUFFER_MAX + 1);
  localparam int CW = (OW > CFG_W) ? OW : CFG_W;
  localparam int NS = (PORTS > FIELD_PORTS) ? PORTS : FIELD_PORTS;

  logic [CFG_W-1:0] limit_cfg_r;
  logic [CW-1:0]    limit_ext;
  logic [OW-1:0]    limit;
  logic             step;

  logic [PORTS-1:0] req_m   [PORTS];
  logic [PORTS-1:0] req_col [PORTS];
  logic [PORTS-1:0] gnt_m   [PORTS];
  logic [PORTS-1:0] gnt_row [PORTS];
  logic [PORTS-1:0] acc_m   [PORTS];
  logic [PORTS-1:0] acc_col [PORTS];
  lane_status_t     st      [NS];
  result_t          result;

  // buffer limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      limit_cfg_r <= cfg_wr_data;
    end
  end

  // clamp the limit to the counter range
  always_comb begin
    limit_ext = CW'(limit_cfg_r);
    limit     = (limit_ext > CW'(BUFFER_MAX)) ? OW'(BUFFER_MAX) : OW'(limit_ext);
  end

  assign step = in_tvalid && in_tready;

  // request, grant and accept matrices between the lanes
  always_comb begin
    for (int a = 0; a < PORTS; a++) begin
      for (int b = 0; b < PORTS; b++) begin
        req_col[a][b] = req_m[b][a];
        gnt_row[a][b] = gnt_m[b][a];
        acc_col[a][b] = acc_m[b][a];
      end
    end
  end

  // input lanes
  for (genvar i = 0; i < PORTS; i++) begin : g_in
    logic       arr_v;
    logic [2:0] arr_d;
    if (i < FIELD_PORTS) begin : g_fed
      assign arr_v = in_tdata[i];
      assign arr_d = in_tdata[FIELD_PORTS + DEST_BITS*i +: DEST_BITS];
    end else begin : g_unfed
      assign arr_v = 1'b0;
      assign arr_d = '0;
    end

    voq_rr_input_lane #(
      .PORTS (PORTS),
      .OW    (OW),
      .PW    (PW)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .arr_valid (arr_v),
      .arr_dest  (arr_d),
      .limit     (limit),
      .grant_in  (gnt_row[i]),
      .request   (req_m[i]),
      .accept    (acc_m[i]),
      .status    (st[i])
    );
  end

  // status of ports that do not exist
  for (genvar k = PORTS; k < NS; k++) begin : g_pad
    assign st[k] = '0;
  end

  // output lanes
  for (genvar j = 0; j < PORTS; j++) begin : g_out
    voq_rr_output_lane #(
      .PORTS (PORTS),
      .PW    (PW)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .step        (step),
      .request_col (req_col[j]),
      .accept_col  (acc_col[j]),
      .grant       (gnt_m[j])
    );
  end

  // merge lane reports into one result
  always_comb begin
    result = '0;
    for (int f = 0; f < FIELD_PORTS; f++) begin
      result.match_valid[f]                         = st[f].matched;
      result.match_output[DEST_BITS*f +: DEST_BITS] = st[f].port;
      result.arrival_dropped[f]                     = st[f].dropped;
    end
  end

  voq_rr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .din        (result),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a refused slot always means a result is waiting
  `VRRM_ASSERT_IMP(a_stall_has_result, !in_tready, out_tvalid, "input stalled with no result")
  // every slot transfer leaves a result to deliver
  `VRRM_ASSERT_NXT(a_slot_gives_result, in_tvalid && in_tready, out_tvalid, "slot lost")

  // an output is matched to at most one input
  for (genvar j = 0; j < PORTS; j++) begin : g_chk
    `VRRM_ASSERT_IMP(a_one_accept, 1'b1, $onehot0(acc_col[j]), "output accepted twice")
  end

endmodule
